// ===== sv/ghbp_pkg.sv =====
// Shared types and constants for the global history branch predictor.
// No dependencies.
package ghbp_pkg;

    localparam int CTR_W = 2;
    localparam logic [CTR_W-1:0] CTR_WEAK_TAKEN = 2'd2;
    localparam logic [CTR_W-1:0] CTR_MAX        = 2'd3;
    localparam logic [CTR_W-1:0] CTR_MIN        = 2'd0;

    localparam int HIST_LEN_W = 5;
    localparam logic [HIST_LEN_W-1:0] HIST_LEN_RESET = 5'd10;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_HISTORY_LEN = 1'b0;

    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
    localparam logic [FIFO_CNT_W-1:0] FIFO_DEPTH = 3'd4;

    typedef struct packed {
        logic predicted_taken;
        logic mispredicted;
    } ghbp_result_t;

endpackage

// ===== sv/global_history_branch_predictor_unit.sv =====
// GAg branch predictor: global history register indexing a table of 2-bit counters.
// Each input transaction is registered in stage 1, then the 4-entry result buffer
// drives m_valid. Throughput 1 per cycle while s_ready is high; s_ready drops when
// the buffer plus stage 1 hold 4 transactions, or during the clearing pass. The RAM
// read is registered and sets the depth; a write-back bypass lets back-to-back hits
// on one counter run bubble-free. Reset: synchronous, active low; history cleared,
// history_len = 10, then a clearing pass sets every counter to weakly taken (s_ready low).
module global_history_branch_predictor_unit #(
    parameter int HISTORY_BITS = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // APB-style configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ghbp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ghbp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ghbp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // resolved branch input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_actual_taken,
    // prediction result
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_predicted_taken,
    output logic                              m_mispredicted
);

    localparam logic [ghbp_pkg::HIST_LEN_W-1:0] MAX_LEN = ghbp_pkg::HIST_LEN_W'(HISTORY_BITS);

    // ---------------- configuration ----------------
    logic [ghbp_pkg::HIST_LEN_W-1:0] history_len_reg;
    logic                            cfg_write;
    logic [0:0]                      reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[2:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            history_len_reg <= ghbp_pkg::HIST_LEN_RESET;
        end else if (cfg_write && (reg_index == ghbp_pkg::REG_HISTORY_LEN)) begin
            history_len_reg <= pwdata[ghbp_pkg::HIST_LEN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_index == ghbp_pkg::REG_HISTORY_LEN) begin
            prdata = ghbp_pkg::APB_DATA_W'(history_len_reg);
        end
    end

    // ---------------- history mask ----------------
    // Effective length clamps to the table width; lengths above it use all bits.
    logic [ghbp_pkg::HIST_LEN_W-1:0] eff_len;
    logic [HISTORY_BITS-1:0]         hist_mask;

    assign eff_len = (history_len_reg > MAX_LEN) ? MAX_LEN : history_len_reg;

    always_comb begin
        for (int i = 0; i < HISTORY_BITS; i++) begin
            hist_mask[i] = (ghbp_pkg::HIST_LEN_W'(i) < eff_len);
        end
    end

    // ---------------- stage 0: accept, index, history update ----------------
    // History only needs HISTORY_BITS bits: every update masks it to <= that length.
    logic [HISTORY_BITS-1:0]         hist_reg;
    logic [HISTORY_BITS-1:0]         hist_next;
    logic [HISTORY_BITS-1:0]         slot;
    logic                            s_accept;
    logic                            ram_busy;
    logic [ghbp_pkg::FIFO_CNT_W-1:0] fifo_count;
    logic [ghbp_pkg::FIFO_CNT_W:0]   in_flight;

    logic                            s1_valid_reg;
    logic [HISTORY_BITS-1:0]         s1_slot_reg;
    logic                            s1_taken_reg;

    // Accept only if every transaction in flight has a buffer slot waiting.
    assign in_flight = {1'b0, fifo_count} + (ghbp_pkg::FIFO_CNT_W + 1)'(s1_valid_reg);
    assign s_ready   = !ram_busy && (in_flight < {1'b0, ghbp_pkg::FIFO_DEPTH});
    assign s_accept  = s_valid && s_ready;

    assign slot      = hist_reg & hist_mask;
    assign hist_next = HISTORY_BITS'({hist_reg, s_actual_taken}) & hist_mask;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept;
            if (s_accept) begin
                hist_reg <= hist_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_slot_reg  <= slot;
            s1_taken_reg <= s_actual_taken;
        end
    end

    // ---------------- stage 1: counter read-modify-write ----------------
    logic [ghbp_pkg::CTR_W-1:0] ram_rd_data;
    logic [ghbp_pkg::CTR_W-1:0] ctr;
    logic [ghbp_pkg::CTR_W-1:0] ctr_next;
    logic                       wb_valid_reg;
    logic [HISTORY_BITS-1:0]    wb_slot_reg;
    logic [ghbp_pkg::CTR_W-1:0] wb_ctr_reg;
    logic                       use_bypass;
    ghbp_pkg::ghbp_result_t     s1_result;

    ghbp_counter_ram #(
        .ADDR_W (HISTORY_BITS)
    ) u_counter_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd_addr (slot),
        .rd_data (ram_rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_slot_reg),
        .wr_data (ctr_next),
        .busy    (ram_busy)
    );

    // The last write is the newest value of its entry; the RAM returns old data when
    // the read and that write share an edge, so take the bypass copy on a match.
    assign use_bypass = wb_valid_reg && (wb_slot_reg == s1_slot_reg);
    assign ctr        = use_bypass ? wb_ctr_reg : ram_rd_data;

    always_comb begin
        ctr_next = ctr;
        if (s1_taken_reg) begin
            if (ctr != ghbp_pkg::CTR_MAX) begin
                ctr_next = ctr + 1'b1;
            end
        end else begin
            if (ctr != ghbp_pkg::CTR_MIN) begin
                ctr_next = ctr - 1'b1;
            end
        end
    end

    // counter >= weakly taken means predict taken
    assign s1_result.predicted_taken = (ctr >= ghbp_pkg::CTR_WEAK_TAKEN);
    assign s1_result.mispredicted    = s1_result.predicted_taken ^ s1_taken_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_valid_reg <= 1'b0;
        end else if (s1_valid_reg) begin
            wb_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            wb_slot_reg <= s1_slot_reg;
            wb_ctr_reg  <= ctr_next;
        end
    end

    // ---------------- output buffer ----------------
    ghbp_pkg::ghbp_result_t out_result;

    ghbp_result_fifo u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s1_valid_reg),
        .push_data (s1_result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_result),
        .count     (fifo_count)
    );

    assign m_predicted_taken = out_result.predicted_taken;
    assign m_mispredicted    = out_result.mispredicted;

endmodule

// ===== sv/ghbp_counter_ram.sv =====
// Pattern table RAM: 2-bit counters, one read and one write port, registered read.
// Runs a clearing pass to weakly taken after reset. Depends on ghbp_pkg.
module ghbp_counter_ram #(
    parameter int ADDR_W = 10
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [ghbp_pkg::CTR_W-1:0]   rd_data,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [ghbp_pkg::CTR_W-1:0]   wr_data,
    output logic                         busy
);

    logic [ghbp_pkg::CTR_W-1:0] mem [2**ADDR_W];
    logic [ghbp_pkg::CTR_W-1:0] rd_data_reg;
    logic                       clearing_reg;
    logic                       clearing_next;
    logic [ADDR_W-1:0]          clear_cnt_reg;
    logic [ADDR_W-1:0]          clear_cnt_next;

    // clear sweep: one entry per cycle
    always_comb begin
        clearing_next  = clearing_reg;
        clear_cnt_next = clear_cnt_reg;
        if (clearing_reg) begin
            clear_cnt_next = clear_cnt_reg + 1'b1;
            if (&clear_cnt_reg) begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg  <= 1'b1;
            clear_cnt_reg <= '0;
        end else begin
            clearing_reg  <= clearing_next;
            clear_cnt_reg <= clear_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clear_cnt_reg] <= ghbp_pkg::CTR_WEAK_TAKEN;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clearing_reg;

endmodule

// ===== sv/ghbp_result_fifo.sv =====
// Four-entry result buffer between the update stage and the m_ channel.
// Depends on ghbp_pkg.
module ghbp_result_fifo (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 push,
    input  ghbp_pkg::ghbp_result_t               push_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output ghbp_pkg::ghbp_result_t               out_data,
    output logic [ghbp_pkg::FIFO_CNT_W-1:0]      count
);

    ghbp_pkg::ghbp_result_t                entry_reg [2**ghbp_pkg::FIFO_PTR_W];
    logic [ghbp_pkg::FIFO_PTR_W-1:0]       wr_ptr_reg;
    logic [ghbp_pkg::FIFO_PTR_W-1:0]       rd_ptr_reg;
    logic [ghbp_pkg::FIFO_CNT_W-1:0]       count_reg;
    logic [ghbp_pkg::FIFO_CNT_W-1:0]       count_next;
    logic                                  pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the GAg global history branch predictor unit.
// Drives resolved branch outcomes, predicts each result in a local model, checks it.
// Depends on ghbp_pkg and global_history_branch_predictor_unit.
`timescale 1ns / 1ps

module testbench;

    localparam int HIST_BITS   = 10;
    localparam int TABLE_SIZE  = 1 << HIST_BITS;
    // Cycles with no transaction anywhere before the run is declared hung. Covers the
    // counter clearing pass after reset plus the longest stall bursts with wide margin.
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 130;
    localparam logic [ghbp_pkg::APB_ADDR_W-1:0] HIST_LEN_ADDR =
        ghbp_pkg::APB_ADDR_W'({ghbp_pkg::REG_HISTORY_LEN, 2'b00});

    // Outcome sequence styles for the random part.
    typedef enum int {
        SEQ_LOOP,     // repeating pattern, what real loops look like
        SEQ_BIASED,   // mostly one direction
        SEQ_NOISE     // uniformly random outcomes
    } seq_style_t;

    logic                            aclk    = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [ghbp_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [ghbp_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [ghbp_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic                            s_actual_taken = 1'b0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic                            m_predicted_taken;
    logic                            m_mispredicted;

    global_history_branch_predictor_unit #(
        .HISTORY_BITS(HIST_BITS)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_actual_taken   (s_actual_taken),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_predicted_taken(m_predicted_taken),
        .m_mispredicted   (m_mispredicted)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Local copy of the predictor state: global history, counter table and
    // the history_len register as last written.
    // ------------------------------------------------------------------
    logic [15:0]                     ghist;
    logic [ghbp_pkg::CTR_W-1:0]      pht [TABLE_SIZE];
    logic [ghbp_pkg::HIST_LEN_W-1:0] hist_len_cfg = ghbp_pkg::HIST_LEN_RESET;

    logic                   branch_q [$];        // outcomes waiting to be driven
    ghbp_pkg::ghbp_result_t prediction_q [$];    // expected results, oldest first

    int  mismatches   = 0;
    int  sent_count   = 0;
    int  checked      = 0;
    int  miss_count   = 0;
    int  cfg_writes   = 0;
    int  s_idle_pct   = 0;
    int  m_idle_pct   = 0;
    logic s_fire      = 1'b0;
    int  quiet_cycles = 0;

    initial begin
        ghist = '0;
        for (int i = 0; i < TABLE_SIZE; i++) pht[i] = ghbp_pkg::CTR_WEAK_TAKEN;
    end

    // Lookup with the state before the update, then train the counter and shift
    // the outcome into the history. Lengths above the table size clamp to it.
    function automatic ghbp_pkg::ghbp_result_t predict_branch(input logic taken);
        logic [ghbp_pkg::HIST_LEN_W-1:0] len_eff;
        logic [15:0]                     mask;
        logic [HIST_BITS-1:0]            slot;
        logic [ghbp_pkg::CTR_W-1:0]      ctr;
        ghbp_pkg::ghbp_result_t          res;
        len_eff = (hist_len_cfg > HIST_BITS) ? ghbp_pkg::HIST_LEN_W'(HIST_BITS) : hist_len_cfg;
        mask    = 16'((17'd1 << len_eff) - 17'd1);
        slot    = HIST_BITS'(ghist & mask);
        ctr     = pht[slot];
        res.predicted_taken = (ctr >= ghbp_pkg::CTR_WEAK_TAKEN);
        res.mispredicted    = (res.predicted_taken != taken);
        if (taken && ctr != ghbp_pkg::CTR_MAX)
            ctr = ctr + 1'b1;
        else if (!taken && ctr != ghbp_pkg::CTR_MIN)
            ctr = ctr - 1'b1;
        pht[slot] = ctr;
        ghist = ((ghist << 1) | 16'(taken)) & mask;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: changes on the falling edge. Valid holds with stable data
    // until the transaction is taken; random idle bursts come in between.
    // ------------------------------------------------------------------
    int s_gap = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (s_gap > 0) begin
                s_gap--;
                s_valid <= 1'b0;
            end else if (branch_q.size() != 0 && $urandom_range(0, 99) < s_idle_pct) begin
                s_gap = $urandom_range(1, 9) - 1;
                s_valid <= 1'b0;
            end else if (branch_q.size() != 0) begin
                s_actual_taken <= branch_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side backpressure, same burst scheme.
    int m_gap = 0;
    always @(negedge aclk) begin
        if (m_gap > 0) begin
            m_gap--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < m_idle_pct) begin
            m_gap = $urandom_range(1, 9) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitors on the rising edge: predict on each accepted input transaction,
    // compare each accepted result against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        ghbp_pkg::ghbp_result_t exp_res;
        s_fire <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            prediction_q.push_back(predict_branch(s_actual_taken));
            sent_count++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (prediction_q.size() == 0) begin
                $display("%0t: unexpected result transaction: expected none, %s",
                         $time, "actual below");
                $display("%0t:   actual pred=%0b miss=%0b",
                         $time, m_predicted_taken, m_mispredicted);
                mismatches++;
            end else begin
                exp_res = prediction_q.pop_front();
                checked++;
                if (m_mispredicted) miss_count++;
                if (m_predicted_taken !== exp_res.predicted_taken) begin
                    $display("%0t: predicted_taken mismatch: expected %0b actual %0b",
                             $time, exp_res.predicted_taken, m_predicted_taken);
                    mismatches++;
                end
                if (m_mispredicted !== exp_res.mispredicted) begin
                    $display("%0t: mispredicted mismatch: expected %0b actual %0b",
                             $time, exp_res.mispredicted, m_mispredicted);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: any transaction on either channel or a register write counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pwrite && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d predictions still pending",
                     $time, STALL_LIMIT, prediction_q.size());
            $display("global_history_branch_predictor_unit test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // APB write: setup cycle, then access cycle; lands on the edge with pready high.
    task automatic write_history_len(input logic [ghbp_pkg::APB_DATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= HIST_LEN_ADDR;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        hist_len_cfg = value[ghbp_pkg::HIST_LEN_W-1:0];
        cfg_writes++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Block is idle once everything has been sent and answered; a few extra cycles
    // cover the two-stage pipeline before the register is touched.
    task automatic wait_drained();
        while (branch_q.size() != 0 || s_valid || prediction_q.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic push_repeat(input logic taken, input int n);
        repeat (n) branch_q.push_back(taken);
    endtask

    // Random outcome stream mixing loop patterns, biased runs and noise. Loop
    // patterns dominate since they are what lets the history train counters.
    task automatic push_random_stream(input int n);
        seq_style_t      style;
        logic [11:0]     pattern;
        int              period;
        int              run;
        logic            bias;
        int              pick;
        while (n > 0) begin
            pick  = $urandom_range(0, 9);
            style = (pick < 5) ? SEQ_LOOP : (pick < 8) ? SEQ_BIASED : SEQ_NOISE;
            run   = $urandom_range(10, 60);
            if (run > n) run = n;
            pattern = 12'($urandom);
            period  = $urandom_range(1, 12);
            bias    = 1'($urandom);
            for (int i = 0; i < run; i++) begin
                case (style)
                    SEQ_LOOP:   branch_q.push_back(pattern[i % period]);
                    SEQ_BIASED: branch_q.push_back(($urandom_range(0, 9) == 0) ? !bias : bias);
                    default:    branch_q.push_back(1'($urandom));
                endcase
            end
            n -= run;
        end
    endtask

    task automatic pick_idling();
        int choice [4] = '{0, 10, 30, 60};
        s_idle_pct = choice[$urandom_range(0, 3)];
        m_idle_pct = choice[$urandom_range(0, 3)];
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        // History lengths for the random phases: 16 and the all-ones value 31
        // (both clamped), short ones, just past the table, 5, then a couple of random picks.
        logic [ghbp_pkg::APB_DATA_W-1:0] len_plan [8];
        len_plan = '{32'd16, 32'd31, 32'd1, 32'd3, 32'd11, 32'd5,
                     ghbp_pkg::APB_DATA_W'($urandom_range(0, 31)),
                     ghbp_pkg::APB_DATA_W'($urandom_range(0, 31))};

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed, reset length of 10: a long taken run fills the history with ones
        // and drives that counter to saturation, then a couple of not-taken.
        pick_idling();
        push_repeat(1'b1, 12);
        push_repeat(1'b0, 2);
        wait_drained();

        // Zero length: everything lands on counter 0. Saturate at 3, walk it down
        // to 0 with mispredictions on the way, then alternate.
        write_history_len('0);
        push_repeat(1'b1, 3);
        push_repeat(1'b0, 5);
        branch_q.push_back(1'b1);
        branch_q.push_back(1'b0);
        wait_drained();

        // Random phases. The history and table carry over across each length change.
        foreach (len_plan[i]) begin
            write_history_len(len_plan[i]);
            pick_idling();
            push_random_stream(PHASE_ITEMS + $urandom_range(0, 40));
            wait_drained();
        end

        // A short length again to shrink a full history.
        write_history_len(32'd2);
        pick_idling();
        push_random_stream(PHASE_ITEMS);
        wait_drained();

        // Last phase: back to the reset length, no idling on either side.
        write_history_len(32'd10);
        s_idle_pct = 0;
        m_idle_pct = 0;
        push_random_stream(PHASE_ITEMS);
        wait_drained();
        repeat (8) @(posedge aclk);

        if (prediction_q.size() != 0) begin
            $display("%0t: %0d predictions never answered", $time, prediction_q.size());
            mismatches++;
        end

        $display("Covered %0d branch outcomes over %0d history length writes %s",
                 sent_count, cfg_writes, "(0, 1..16, clamped >10).");
        $display("Checked %0d predictions, %0d of them mispredicted, %0d mismatches.",
                 checked, miss_count, mismatches);
        if (mismatches == 0) begin
            $display("global_history_branch_predictor_unit test passed");
        end else begin
            $display("global_history_branch_predictor_unit test failed");
        end
        $finish;
    end

endmodule
